[hw/rtl/rtpg_pkg.sv]
// Package for the radar target polar gate: shared constants, register codes
// and the CORDIC arctangent table. Depends on nothing.
package rtpg_pkg;

    // Default number of CORDIC iterations and table size.
    localparam int ANGLE_ITERATIONS_DEF = 14;
    localparam int ATAN_ENTRIES = 24;

    // Angle constants: radians * 2^30 and radians * 2^13.
    localparam int HALF_PI_Q30 = 1686629713;
    localparam int PI_Q13 = 25736;
    localparam int HALF_PI_Q13 = 12868;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_MIN_RANGE = 3'd0,
        REG_MAX_RANGE = 3'd1,
        REG_MIN_AZ    = 3'd2,
        REG_MAX_AZ    = 3'd3,
        REG_MIN_EL    = 3'd4,
        REG_MAX_EL    = 3'd5
    } cfg_reg_t;

    // Register reset values.
    localparam logic [24:0] MIN_RANGE_RST = 25'd0;
    localparam logic [24:0] MAX_RANGE_RST = 25'd33554431;

    // Truncated arctangent of 2^-i in radians * 2^30.
    function automatic logic [30:0] atan_q30(input int unsigned i);
        logic [30:0] v;
        unique case (i)
            0: v = 31'd843314856;
            1: v = 31'd497837829;
            2: v = 31'd263043836;
            3: v = 31'd133525158;
            4: v = 31'd67021686;
            5: v = 31'd33543515;
            6: v = 31'd16775850;
            7: v = 31'd8388437;
            8: v = 31'd4194282;
            9: v = 31'd2097149;
            10: v = 31'd1048575;
            11: v = 31'd524287;
            12: v = 31'd262143;
            13: v = 31'd131071;
            14: v = 31'd65535;
            15: v = 31'd32767;
            16: v = 31'd16383;
            17: v = 31'd8191;
            18: v = 31'd4095;
            19: v = 31'd2047;
            20: v = 31'd1023;
            21: v = 31'd511;
            22: v = 31'd255;
            23: v = 31'd127;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/rtpg_isqrt.sv]
// Pipelined rounded integer square root, one result bit per stage, with a
// sideband word that travels alongside. Depends on nothing else.
module rtpg_isqrt #(
    parameter int IN_W = 50,
    parameter int SIDE_W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [IN_W-1:0]       in_data,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [IN_W/2:0]       out_root,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int ROOT_W = IN_W / 2;
    localparam int RW = ROOT_W + 2;
    localparam int STEPS = ROOT_W;

    logic [IN_W-1:0]   n_reg [STEPS];
    logic [RW-1:0]     rem_reg [STEPS];
    logic [ROOT_W-1:0] root_reg [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];
    logic              v_reg [STEPS];

    logic              fv_reg;
    logic [ROOT_W:0]   froot_reg;
    logic [SIDE_W-1:0] fside_reg;

    // One digit pair of the radicand per stage.
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [IN_W-1:0]   n_prev;
        logic [RW-1:0]     rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [SIDE_W-1:0] side_prev;
        logic              v_prev;
        logic [RW+1:0]     cand;
        logic [RW+1:0]     trial;
        logic              ge;
        logic [RW-1:0]     rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign n_prev = in_data;
            assign rem_prev = '0;
            assign root_prev = '0;
            assign side_prev = in_side;
            assign v_prev = in_valid;
        end else begin : g_rest
            assign n_prev = n_reg[k-1];
            assign rem_prev = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign v_prev = v_reg[k-1];
        end

        // Try to subtract 4*root+1 from the shifted remainder.
        always_comb
        begin
            cand = {rem_prev, n_prev[IN_W-1 -: 2]};
            trial = (RW + 2)'({root_prev, 2'b01});
            ge = (cand >= trial);
            rem_next = ge ? RW'(cand - trial) : RW'(cand);
            root_next = {root_prev[ROOT_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k] <= n_prev << 2;
                rem_reg[k] <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    // Round to nearest: bump the root when the remainder exceeds it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (en)
        begin
            fv_reg <= v_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            froot_reg <= (ROOT_W + 1)'(root_reg[STEPS-1])
                + (ROOT_W + 1)'(rem_reg[STEPS-1] > RW'(root_reg[STEPS-1]));
            fside_reg <= side_reg[STEPS-1];
        end
    end

    assign out_valid = fv_reg;
    assign out_root = froot_reg;
    assign out_side = fside_reg;

endmodule

[hw/rtl/radar_target_polar_gate.sv]
// Radar target gate: range, azimuth and elevation of a target in the sensor
// frame, dropped when outside the configured windows. Uses rtpg_pkg, rtpg_isqrt.
// Register stages from input to output: 3 + 26 + 4 + 31 + ANGLE_ITERATIONS + 3
// (81 at the default).
// Throughput: one item per cycle; the whole pipeline moves together and halts
// only while the output skid register is full.
// Reset: valid bits clear at once and the windows return to their full ranges.
module radar_target_polar_gate #(
    parameter int ANGLE_ITERATIONS = rtpg_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [24:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [23:0] own_x,
    input  logic signed [23:0] own_y,
    input  logic signed [23:0] own_z,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [23:0] target_x,
    input  logic signed [23:0] target_y,
    input  logic signed [23:0] target_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [24:0]        range_out,
    output logic signed [15:0] azimuth_out,
    output logic signed [14:0] elevation_out
);

    localparam int DW = 25;
    localparam int QPW = 32;
    localparam int MW = 34;
    localparam int PW = 59;
    localparam int RSW = 60;
    localparam int SQW = 49;
    localparam int RGW = 50;
    localparam int MAGW = 58;
    localparam int SV = 30;
    localparam int HQW = 58;
    localparam int HSW = 60;
    localparam int CW = 33;
    localparam int ZW = 34;
    localparam int RNG_SIDE = 3 * RSW;
    localparam int H_SIDE = 3 * SV + ZW + 1 + 25;

    logic en;

    // Configuration registers.
    logic [24:0]        min_range_reg, max_range_reg;
    logic signed [15:0] min_az_reg, max_az_reg;
    logic signed [14:0] min_el_reg, max_el_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg <= rtpg_pkg::MIN_RANGE_RST;
            max_range_reg <= rtpg_pkg::MAX_RANGE_RST;
            min_az_reg <= -16'(rtpg_pkg::PI_Q13);
            max_az_reg <= 16'(rtpg_pkg::PI_Q13);
            min_el_reg <= -15'(rtpg_pkg::HALF_PI_Q13);
            max_el_reg <= 15'(rtpg_pkg::HALF_PI_Q13);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rtpg_pkg::REG_MIN_RANGE: min_range_reg <= cfg_data;
                rtpg_pkg::REG_MAX_RANGE: max_range_reg <= cfg_data;
                rtpg_pkg::REG_MIN_AZ:    min_az_reg <= cfg_data[15:0];
                rtpg_pkg::REG_MAX_AZ:    max_az_reg <= cfg_data[15:0];
                rtpg_pkg::REG_MIN_EL:    min_el_reg <= cfg_data[14:0];
                rtpg_pkg::REG_MAX_EL:    max_el_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Stage 1: world offset and quaternion products.
    logic                  s1_v_reg;
    logic signed [DW-1:0]  s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic signed [QPW-1:0] s1_ww_reg, s1_xx_reg, s1_yy_reg, s1_zz_reg;
    logic signed [QPW-1:0] s1_xy_reg, s1_xz_reg, s1_yz_reg;
    logic signed [QPW-1:0] s1_wx_reg, s1_wy_reg, s1_wz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dx_reg <= DW'(target_x) - DW'(own_x);
            s1_dy_reg <= DW'(target_y) - DW'(own_y);
            s1_dz_reg <= DW'(target_z) - DW'(own_z);
            s1_ww_reg <= quat_w * quat_w;
            s1_xx_reg <= quat_x * quat_x;
            s1_yy_reg <= quat_y * quat_y;
            s1_zz_reg <= quat_z * quat_z;
            s1_xy_reg <= quat_x * quat_y;
            s1_xz_reg <= quat_x * quat_z;
            s1_yz_reg <= quat_y * quat_z;
            s1_wx_reg <= quat_w * quat_x;
            s1_wy_reg <= quat_w * quat_y;
            s1_wz_reg <= quat_w * quat_z;
        end
    end

    // Stage 2: homogeneous rotation matrix (transposed) and offset squares.
    logic                 s2_v_reg;
    logic signed [MW-1:0] s2_m_reg [9];
    logic signed [DW-1:0] s2_dx_reg, s2_dy_reg, s2_dz_reg;
    logic [SQW-1:0]       s2_sqx_reg, s2_sqy_reg, s2_sqz_reg;
    logic signed [2*DW-1:0] sqx, sqy, sqz;

    assign sqx = s1_dx_reg * s1_dx_reg;
    assign sqy = s1_dy_reg * s1_dy_reg;
    assign sqz = s1_dz_reg * s1_dz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_m_reg[0] <= MW'(s1_ww_reg) + MW'(s1_xx_reg) - MW'(s1_yy_reg) - MW'(s1_zz_reg);
            s2_m_reg[1] <= (MW'(s1_xy_reg) + MW'(s1_wz_reg)) <<< 1;
            s2_m_reg[2] <= (MW'(s1_xz_reg) - MW'(s1_wy_reg)) <<< 1;
            s2_m_reg[3] <= (MW'(s1_xy_reg) - MW'(s1_wz_reg)) <<< 1;
            s2_m_reg[4] <= MW'(s1_ww_reg) - MW'(s1_xx_reg) + MW'(s1_yy_reg) - MW'(s1_zz_reg);
            s2_m_reg[5] <= (MW'(s1_yz_reg) + MW'(s1_wx_reg)) <<< 1;
            s2_m_reg[6] <= (MW'(s1_xz_reg) + MW'(s1_wy_reg)) <<< 1;
            s2_m_reg[7] <= (MW'(s1_yz_reg) - MW'(s1_wx_reg)) <<< 1;
            s2_m_reg[8] <= MW'(s1_ww_reg) - MW'(s1_xx_reg) - MW'(s1_yy_reg) + MW'(s1_zz_reg);
            s2_dx_reg <= s1_dx_reg;
            s2_dy_reg <= s1_dy_reg;
            s2_dz_reg <= s1_dz_reg;
            s2_sqx_reg <= sqx[SQW-1:0];
            s2_sqy_reg <= sqy[SQW-1:0];
            s2_sqz_reg <= sqz[SQW-1:0];
        end
    end

    // Stage 3: matrix times offset, and the squared range.
    logic                 s3_v_reg;
    logic signed [PW-1:0] s3_p_reg [9];
    logic signed [PW-1:0] prod [9];
    logic [RGW-1:0]       s3_rsum_reg;

    for (genvar j = 0; j < 9; j++) begin : g_prod
        logic signed [DW-1:0] dsel;
        if (j % 3 == 0) begin : g_dx
            assign dsel = s2_dx_reg;
        end else if (j % 3 == 1) begin : g_dy
            assign dsel = s2_dy_reg;
        end else begin : g_dz
            assign dsel = s2_dz_reg;
        end
        assign prod[j] = s2_m_reg[j] * dsel;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 9; j++)
            begin
                s3_p_reg[j] <= prod[j];
            end
            s3_rsum_reg <= RGW'(s2_sqx_reg) + RGW'(s2_sqy_reg) + RGW'(s2_sqz_reg);
        end
    end

    // Range square root; the rotated vector sums ride along as sideband.
    logic signed [RSW-1:0] rx_sum, ry_sum, rz_sum;
    logic                  rng_v;
    logic [RGW/2:0]        rng_root;
    logic [RNG_SIDE-1:0]   rng_side;

    assign rx_sum = RSW'(s3_p_reg[0]) + RSW'(s3_p_reg[1]) + RSW'(s3_p_reg[2]);
    assign ry_sum = RSW'(s3_p_reg[3]) + RSW'(s3_p_reg[4]) + RSW'(s3_p_reg[5]);
    assign rz_sum = RSW'(s3_p_reg[6]) + RSW'(s3_p_reg[7]) + RSW'(s3_p_reg[8]);

    rtpg_isqrt #(
        .IN_W   (RGW),
        .SIDE_W (RNG_SIDE)
    ) u_range_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_v_reg),
        .in_data   (s3_rsum_reg),
        .in_side   ({rx_sum, ry_sum, rz_sum}),
        .out_valid (rng_v),
        .out_root  (rng_root),
        .out_side  (rng_side)
    );

    // Stage 5: magnitudes and their union for the scale search.
    logic signed [RSW-1:0] rx_full, ry_full, rz_full;
    logic signed [RSW-1:0] rx_abs, ry_abs, rz_abs;
    logic                  s5_v_reg;
    logic [MAGW-1:0]       s5_mx_reg, s5_my_reg, s5_mz_reg;
    logic                  s5_nx_reg, s5_ny_reg, s5_nz_reg;
    logic [24:0]           s5_range_reg;

    assign rx_full = rng_side[3*RSW-1 -: RSW];
    assign ry_full = rng_side[2*RSW-1 -: RSW];
    assign rz_full = rng_side[RSW-1:0];
    assign rx_abs = rx_full[RSW-1] ? -rx_full : rx_full;
    assign ry_abs = ry_full[RSW-1] ? -ry_full : ry_full;
    assign rz_abs = rz_full[RSW-1] ? -rz_full : rz_full;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_mx_reg <= rx_abs[MAGW-1:0];
            s5_my_reg <= ry_abs[MAGW-1:0];
            s5_mz_reg <= rz_abs[MAGW-1:0];
            s5_nx_reg <= rx_full[RSW-1];
            s5_ny_reg <= ry_full[RSW-1];
            s5_nz_reg <= rz_full[RSW-1];
            s5_range_reg <= rng_root[24:0];
        end
    end

    // Stage 6: common right shift that brings every magnitude below 2^29.
    logic [MAGW-1:0] mag_union;
    logic [4:0]      shift_next;
    logic            s6_v_reg;
    logic [4:0]      s6_shift_reg;
    logic [MAGW-1:0] s6_mx_reg, s6_my_reg, s6_mz_reg;
    logic            s6_nx_reg, s6_ny_reg, s6_nz_reg;
    logic [24:0]     s6_range_reg;

    assign mag_union = s5_mx_reg | s5_my_reg | s5_mz_reg;

    always_comb
    begin
        shift_next = '0;
        for (int i = SV - 1; i < MAGW; i++)
        begin
            if (mag_union[i])
            begin
                shift_next = 5'(i - (SV - 2));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_shift_reg <= shift_next;
            s6_mx_reg <= s5_mx_reg;
            s6_my_reg <= s5_my_reg;
            s6_mz_reg <= s5_mz_reg;
            s6_nx_reg <= s5_nx_reg;
            s6_ny_reg <= s5_ny_reg;
            s6_nz_reg <= s5_nz_reg;
            s6_range_reg <= s5_range_reg;
        end
    end

    // Stage 7: shrink toward zero and restore signs.
    logic [MAGW-1:0]      shx, shy, shz;
    logic signed [SV-1:0] vx, vy, vz;
    logic                 s7_v_reg;
    logic signed [SV-1:0] s7_x_reg, s7_y_reg, s7_z_reg;
    logic [24:0]          s7_range_reg;

    assign shx = s6_mx_reg >> s6_shift_reg;
    assign shy = s6_my_reg >> s6_shift_reg;
    assign shz = s6_mz_reg >> s6_shift_reg;
    assign vx = SV'({1'b0, shx[SV-2:0]});
    assign vy = SV'({1'b0, shy[SV-2:0]});
    assign vz = SV'({1'b0, shz[SV-2:0]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_x_reg <= s6_nx_reg ? -vx : vx;
            s7_y_reg <= s6_ny_reg ? -vy : vy;
            s7_z_reg <= s6_nz_reg ? -vz : vz;
            s7_range_reg <= s6_range_reg;
        end
    end

    // Stage 8: azimuth pre-rotation, degenerate check, horizontal squares.
    logic signed [2*SV-1:0] hsqx, hsqy;
    logic signed [SV-1:0]   ax_next, ay_next;
    logic signed [ZW-1:0]   z0_next;
    logic                   s8_v_reg;
    logic [HQW-1:0]         s8_hx_reg, s8_hy_reg;
    logic signed [SV-1:0]   s8_ax_reg, s8_ay_reg, s8_rz_reg;
    logic signed [ZW-1:0]   s8_z0_reg;
    logic                   s8_degen_reg;
    logic [24:0]            s8_range_reg;

    assign hsqx = s7_x_reg * s7_x_reg;
    assign hsqy = s7_y_reg * s7_y_reg;

    always_comb
    begin
        ax_next = s7_x_reg;
        ay_next = s7_y_reg;
        z0_next = '0;
        if (s7_x_reg < 0)
        begin
            if (s7_y_reg >= 0)
            begin
                ax_next = s7_y_reg;
                ay_next = -s7_x_reg;
                z0_next = ZW'(rtpg_pkg::HALF_PI_Q30);
            end
            else
            begin
                ax_next = -s7_y_reg;
                ay_next = s7_x_reg;
                z0_next = -ZW'(rtpg_pkg::HALF_PI_Q30);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_hx_reg <= hsqx[HQW-1:0];
            s8_hy_reg <= hsqy[HQW-1:0];
            s8_ax_reg <= ax_next;
            s8_ay_reg <= ay_next;
            s8_z0_reg <= z0_next;
            s8_rz_reg <= s7_z_reg;
            s8_degen_reg <= (s7_x_reg == '0) && (s7_y_reg == '0);
            s8_range_reg <= s7_range_reg;
        end
    end

    // Horizontal length square root with the angle inputs as sideband.
    logic               h_v;
    logic [HSW/2:0]     h_root;
    logic [H_SIDE-1:0]  h_side;

    rtpg_isqrt #(
        .IN_W   (HSW),
        .SIDE_W (H_SIDE)
    ) u_horiz_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s8_v_reg),
        .in_data   (HSW'(s8_hx_reg) + HSW'(s8_hy_reg)),
        .in_side   ({s8_ax_reg, s8_ay_reg, s8_z0_reg, s8_rz_reg, s8_degen_reg,
                     s8_range_reg}),
        .out_valid (h_v),
        .out_root  (h_root),
        .out_side  (h_side)
    );

    // Vectoring CORDIC, one iteration per stage, azimuth and elevation side by side.
    logic signed [CW-1:0] c_axr [ANGLE_ITERATIONS];
    logic signed [CW-1:0] c_ayr [ANGLE_ITERATIONS];
    logic signed [ZW-1:0] c_azr [ANGLE_ITERATIONS];
    logic signed [CW-1:0] c_exr [ANGLE_ITERATIONS];
    logic signed [CW-1:0] c_eyr [ANGLE_ITERATIONS];
    logic signed [ZW-1:0] c_ezr [ANGLE_ITERATIONS];
    logic                 c_degen_reg [ANGLE_ITERATIONS];
    logic                 c_neg_reg [ANGLE_ITERATIONS];
    logic [24:0]          c_range_reg [ANGLE_ITERATIONS];
    logic                 c_v_reg [ANGLE_ITERATIONS];

    logic signed [SV-1:0] h_ax, h_ay, h_rz;
    logic signed [ZW-1:0] h_z0;

    assign h_ax = h_side[H_SIDE-1 -: SV];
    assign h_ay = h_side[H_SIDE-SV-1 -: SV];
    assign h_z0 = h_side[H_SIDE-2*SV-1 -: ZW];
    assign h_rz = h_side[25+SV:26];

    for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cordic
        logic signed [CW-1:0] ax, ay, ex, ey;
        logic signed [ZW-1:0] az, ez, step;
        logic                 degen, neg, v;
        logic [24:0]          rng;

        if (i == 0) begin : g_first
            assign ax = CW'(h_ax);
            assign ay = CW'(h_ay);
            assign az = h_z0;
            assign ex = CW'({1'b0, h_root});
            assign ey = CW'(h_rz);
            assign ez = '0;
            assign degen = h_side[25];
            assign neg = h_rz[SV-1];
            assign rng = h_side[24:0];
            assign v = h_v;
        end else begin : g_rest
            assign ax = c_axr[i-1];
            assign ay = c_ayr[i-1];
            assign az = c_azr[i-1];
            assign ex = c_exr[i-1];
            assign ey = c_eyr[i-1];
            assign ez = c_ezr[i-1];
            assign degen = c_degen_reg[i-1];
            assign neg = c_neg_reg[i-1];
            assign rng = c_range_reg[i-1];
            assign v = c_v_reg[i-1];
        end

        assign step = ZW'(rtpg_pkg::atan_q30(i));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                c_v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                c_v_reg[i] <= v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!ay[CW-1])
                begin
                    c_axr[i] <= ax + (ay >>> i);
                    c_ayr[i] <= ay - (ax >>> i);
                    c_azr[i] <= az + step;
                end
                else
                begin
                    c_axr[i] <= ax - (ay >>> i);
                    c_ayr[i] <= ay + (ax >>> i);
                    c_azr[i] <= az - step;
                end
                if (!ey[CW-1])
                begin
                    c_exr[i] <= ex + (ey >>> i);
                    c_eyr[i] <= ey - (ex >>> i);
                    c_ezr[i] <= ez + step;
                end
                else
                begin
                    c_exr[i] <= ex - (ey >>> i);
                    c_eyr[i] <= ey + (ex >>> i);
                    c_ezr[i] <= ez - step;
                end
                c_degen_reg[i] <= degen;
                c_neg_reg[i] <= neg;
                c_range_reg[i] <= rng;
            end
        end
    end

    // Round angles half up to Q3.13 (elevation Q2.13), clamp, and apply the degenerate case.
    localparam int LAST = ANGLE_ITERATIONS - 1;
    localparam int QW = ZW + 1 - 17;

    logic signed [ZW:0]   az_rnd, el_rnd;
    logic signed [QW-1:0] az_q, el_q;
    logic signed [QW-1:0] az_lim, el_lim;
    logic signed [15:0]   az_next;
    logic signed [14:0]   el_next;
    logic                 r_v_reg;
    logic signed [15:0]   r_az_reg;
    logic signed [14:0]   r_el_reg;
    logic [24:0]          r_range_reg;

    assign az_rnd = (ZW + 1)'(c_azr[LAST]) + (ZW + 1)'(65536);
    assign el_rnd = (ZW + 1)'(c_ezr[LAST]) + (ZW + 1)'(65536);
    assign az_q = QW'(az_rnd >>> 17);
    assign el_q = QW'(el_rnd >>> 17);

    always_comb
    begin
        az_lim = az_q;
        if (az_q > QW'(rtpg_pkg::PI_Q13))
        begin
            az_lim = QW'(rtpg_pkg::PI_Q13);
        end
        else if (az_q < -QW'(rtpg_pkg::PI_Q13))
        begin
            az_lim = -QW'(rtpg_pkg::PI_Q13);
        end
        el_lim = el_q;
        if (el_q > QW'(rtpg_pkg::HALF_PI_Q13))
        begin
            el_lim = QW'(rtpg_pkg::HALF_PI_Q13);
        end
        else if (el_q < -QW'(rtpg_pkg::HALF_PI_Q13))
        begin
            el_lim = -QW'(rtpg_pkg::HALF_PI_Q13);
        end
        if (c_degen_reg[LAST])
        begin
            az_next = 16'(rtpg_pkg::HALF_PI_Q13);
            el_next = c_neg_reg[LAST] ? -15'(rtpg_pkg::HALF_PI_Q13)
                                      : 15'(rtpg_pkg::HALF_PI_Q13);
        end
        else
        begin
            az_next = az_lim[15:0];
            el_next = el_lim[14:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_az_reg <= az_next;
            r_el_reg <= el_next;
            r_range_reg <= c_range_reg[LAST];
        end
    end

    // Window check; a dropped target leaves a bubble.
    logic               pass;
    logic               g_v_reg;
    logic [24:0]        g_range_reg;
    logic signed [15:0] g_az_reg;
    logic signed [14:0] g_el_reg;

    assign pass = (r_range_reg >= min_range_reg) && (r_range_reg <= max_range_reg)
        && (r_az_reg >= min_az_reg) && (r_az_reg <= max_az_reg)
        && (r_el_reg >= min_el_reg) && (r_el_reg <= max_el_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_range_reg <= r_range_reg;
            g_az_reg <= r_az_reg;
            g_el_reg <= r_el_reg;
        end
    end

    // Valid bits of the stages owned by this module.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
            s8_v_reg <= 1'b0;
            r_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s5_v_reg <= rng_v;
            s6_v_reg <= s5_v_reg;
            s7_v_reg <= s6_v_reg;
            s8_v_reg <= s7_v_reg;
            r_v_reg <= c_v_reg[LAST];
            g_v_reg <= r_v_reg && pass;
        end
    end

    // Output register with a skid stage; the pipeline halts while skid is full.
    logic               out_v_reg, skid_v_reg;
    logic [24:0]        out_range_reg, skid_range_reg;
    logic signed [15:0] out_az_reg, skid_az_reg;
    logic signed [14:0] out_el_reg, skid_el_reg;

    assign en = !skid_v_reg;
    assign in_stall = skid_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (!out_stall)
            begin
                out_v_reg <= 1'b1;
                skid_v_reg <= 1'b0;
            end
        end
        else if (g_v_reg)
        begin
            if (!out_v_reg || !out_stall)
            begin
                out_v_reg <= 1'b1;
            end
            else
            begin
                skid_v_reg <= 1'b1;
            end
        end
        else if (!out_stall)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (!out_stall)
            begin
                out_range_reg <= skid_range_reg;
                out_az_reg <= skid_az_reg;
                out_el_reg <= skid_el_reg;
            end
        end
        else if (g_v_reg)
        begin
            if (!out_v_reg || !out_stall)
            begin
                out_range_reg <= g_range_reg;
                out_az_reg <= g_az_reg;
                out_el_reg <= g_el_reg;
            end
            else
            begin
                skid_range_reg <= g_range_reg;
                skid_az_reg <= g_az_reg;
                skid_el_reg <= g_el_reg;
            end
        end
    end

    assign out_valid = out_v_reg;
    assign range_out = out_range_reg;
    assign azimuth_out = out_az_reg;
    assign elevation_out = out_el_reg;

endmodule

[tb/sv/radar_target_polar_gate_tb.sv]
// Self-checking testbench for radar_target_polar_gate: a queue-fed driver, a
// result monitor and a bit-exact polar predictor. Depends on rtpg_pkg and the RTL.
module radar_target_polar_gate_tb;

    typedef struct {
        logic signed [23:0] own_x, own_y, own_z;
        logic signed [15:0] qw, qx, qy, qz;
        logic signed [23:0] tgt_x, tgt_y, tgt_z;
    } target_item_t;

    typedef struct {
        logic [24:0]        range_v;
        logic signed [15:0] az_v;
        logic signed [14:0] el_v;
    } polar_t;

    // Arctangent table in radians * 2^30, truncated.
    localparam longint ATAN_TBL [0:13] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071
    };
    localparam int DRAIN_CYCLES = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [24:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b1;
    logic [24:0] range_out;
    logic signed [15:0] azimuth_out;
    logic signed [14:0] elevation_out;

    target_item_t cur = '{default: '0};
    target_item_t item_q[$];
    polar_t polar_expect_q[$];
    bit sent = 0;
    bit hold = 0;
    int send_idle = 9;
    int recv_idle = 82;
    int errors = 0;

    // Window registers as the block should hold them.
    logic [24:0] win_rmin, win_rmax;
    longint win_azmin, win_azmax, win_elmin, win_elmax;

    radar_target_polar_gate dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .own_x(cur.own_x), .own_y(cur.own_y), .own_z(cur.own_z),
        .quat_w(cur.qw), .quat_x(cur.qx), .quat_y(cur.qy), .quat_z(cur.qz),
        .target_x(cur.tgt_x), .target_y(cur.tgt_y), .target_z(cur.tgt_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .range_out(range_out), .azimuth_out(azimuth_out),
        .elevation_out(elevation_out)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #(8 * 3000000);
        $display("radar_target_polar_gate_tb: errors");
        $finish;
    end

    function automatic longint unsigned mag64(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Square root rounded to nearest, bit by bit.
    function automatic longint unsigned sqrt_rnd(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        if (n > r)
            r++;
        return r;
    endfunction

    // Vectoring rotation toward the x axis, accumulating the angle.
    function automatic longint vector_angle(input longint x, input longint y, input longint z);
        longint xs, ys;
        for (int i = 0; i < 14; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys; y -= xs; z += ATAN_TBL[i];
            end
            else
            begin
                x -= ys; y += xs; z -= ATAN_TBL[i];
            end
        end
        return z;
    endfunction

    function automatic longint round_q13(input longint z, input longint lim);
        longint q;
        q = (z + 65536) >>> 17;
        if (q > lim) q = lim;
        if (q < -lim) q = -lim;
        return q;
    endfunction

    function automatic longint shrink_mag(input longint v, input int s);
        longint m;
        m = longint'(mag64(v) >> s);
        return (v < 0) ? -m : m;
    endfunction

    // Polar coordinates of the target and the window decision.
    function automatic bit predict_polar(input target_item_t it, output polar_t res);
        longint dx, dy, dz, w, x, y, z, rx, ry, rz, az, el, h, ax, ay, z0;
        longint ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint unsigned rng, m;
        int s;
        dx = longint'(it.tgt_x) - longint'(it.own_x);
        dy = longint'(it.tgt_y) - longint'(it.own_y);
        dz = longint'(it.tgt_z) - longint'(it.own_z);
        w = it.qw; x = it.qx; y = it.qy; z = it.qz;
        ww = w * w; xx = x * x; yy = y * y; zz = z * z;
        xy = x * y; xz = x * z; yz = y * z;
        wx = w * x; wy = w * y; wz = w * z;
        rng = sqrt_rnd(mag64(dx) * mag64(dx) + mag64(dy) * mag64(dy) + mag64(dz) * mag64(dz));
        rx = (ww + xx - yy - zz) * dx + 2 * (xy + wz) * dy + 2 * (xz - wy) * dz;
        ry = 2 * (xy - wz) * dx + (ww - xx + yy - zz) * dy + 2 * (yz + wx) * dz;
        rz = 2 * (xz + wy) * dx + 2 * (yz - wx) * dy + (ww - xx - yy + zz) * dz;
        m = mag64(rx);
        if (mag64(ry) > m) m = mag64(ry);
        if (mag64(rz) > m) m = mag64(rz);
        s = 0;
        while ((m >> s) >= (64'd1 << 29))
            s++;
        rx = shrink_mag(rx, s);
        ry = shrink_mag(ry, s);
        rz = shrink_mag(rz, s);
        if (rx == 0 && ry == 0)
        begin
            az = rtpg_pkg::HALF_PI_Q13;
            el = (rz >= 0) ? rtpg_pkg::HALF_PI_Q13 : -rtpg_pkg::HALF_PI_Q13;
        end
        else
        begin
            h = longint'(sqrt_rnd(mag64(rx) * mag64(rx) + mag64(ry) * mag64(ry)));
            ax = rx; ay = ry; z0 = 0;
            // Left half plane is pre-rotated by a quarter turn.
            if (rx < 0)
            begin
                if (ry >= 0)
                begin
                    ax = ry; ay = -rx; z0 = rtpg_pkg::HALF_PI_Q30;
                end
                else
                begin
                    ax = -ry; ay = rx; z0 = -longint'(rtpg_pkg::HALF_PI_Q30);
                end
            end
            az = round_q13(vector_angle(ax, ay, z0), rtpg_pkg::PI_Q13);
            el = round_q13(vector_angle(h, rz, 0), rtpg_pkg::HALF_PI_Q13);
        end
        res.range_v = rng[24:0];
        res.az_v = az[15:0];
        res.el_v = el[14:0];
        if (rng < win_rmin || rng > win_rmax) return 0;
        if (az < win_azmin || az > win_azmax) return 0;
        if (el < win_elmin || el > win_elmax) return 0;
        return 1;
    endfunction

    // Appends one item to the driver's queue.
    task automatic add_item(input target_item_t t);
        item_q.insert(item_q.size(), t);
    endtask

    // Driver: a new item replaces the old one only after it was taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || sent)
            begin
                if (item_q.size() > 0 && !hold && $urandom_range(99) >= send_idle)
                begin
                    cur = item_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            sent = 0;
            out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // Accepted inputs feed the predictor.
    always @(posedge clk)
    begin
        polar_t p;
        if (rst_n && in_valid && !in_stall)
        begin
            if (predict_polar(cur, p))
                polar_expect_q.insert(polar_expect_q.size(), p);
            sent = 1;
        end
    end

    // Monitor: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        polar_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (polar_expect_q.size() == 0)
            begin
                $error("unexpected result range=%0d az=%0d el=%0d",
                       range_out, azimuth_out, elevation_out);
                errors++;
            end
            else
            begin
                e = polar_expect_q.pop_front();
                if (range_out !== e.range_v)
                begin
                    $error("range_out expected %0d actual %0d", e.range_v, range_out);
                    errors++;
                end
                if (azimuth_out !== e.az_v)
                begin
                    $error("azimuth_out expected %0d actual %0d", e.az_v, azimuth_out);
                    errors++;
                end
                if (elevation_out !== e.el_v)
                begin
                    $error("elevation_out expected %0d actual %0d", e.el_v, elevation_out);
                    errors++;
                end
            end
        end
    end

    function automatic int rnd_in(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic target_item_t mk_item(input int ox, oy, oz, qw, qx, qy, qz,
                                             input int tx, ty, tz);
        target_item_t t;
        t.own_x = 24'(ox); t.own_y = 24'(oy); t.own_z = 24'(oz);
        t.qw = 16'(qw); t.qx = 16'(qx); t.qy = 16'(qy); t.qz = 16'(qz);
        t.tgt_x = 24'(tx); t.tgt_y = 24'(ty); t.tgt_z = 24'(tz);
        return t;
    endfunction

    // Random target: mostly nearby offsets, some far, some on axes or at the sensor.
    function automatic target_item_t rand_item();
        target_item_t t;
        int kind, span;
        t.own_x = 24'($urandom); t.own_y = 24'($urandom); t.own_z = 24'($urandom);
        kind = $urandom_range(9);
        case ($urandom_range(5))
            0: begin t.qw = 16'(16384); t.qx = '0; t.qy = '0; t.qz = '0; end
            1: begin t.qw = '0; t.qx = '0; t.qy = '0; t.qz = '0; end
            default:
            begin
                t.qw = 16'(rnd_in(-16384, 16384)); t.qx = 16'(rnd_in(-16384, 16384));
                t.qy = 16'(rnd_in(-16384, 16384)); t.qz = 16'(rnd_in(-16384, 16384));
            end
        endcase
        span = 1 << $urandom_range(22, 1);
        if (kind < 3)
        begin
            t.tgt_x = 24'($urandom); t.tgt_y = 24'($urandom); t.tgt_z = 24'($urandom);
        end
        else
        begin
            t.tgt_x = 24'(t.own_x + rnd_in(-span, span));
            t.tgt_y = 24'(t.own_y + rnd_in(-span, span));
            t.tgt_z = 24'(t.own_z + rnd_in(-span, span));
            if (kind == 8)
            begin
                t.tgt_x = t.own_x; t.tgt_y = t.own_y;
            end
            if (kind == 9)
                t.tgt_y = t.own_y;
        end
        return t;
    endfunction

    task automatic wait_drained();
        while (item_q.size() > 0 || in_valid || polar_expect_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [24:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            rtpg_pkg::REG_MIN_RANGE: win_rmin = val;
            rtpg_pkg::REG_MAX_RANGE: win_rmax = val;
            rtpg_pkg::REG_MIN_AZ: win_azmin = longint'($signed(val[15:0]));
            rtpg_pkg::REG_MAX_AZ: win_azmax = longint'($signed(val[15:0]));
            rtpg_pkg::REG_MIN_EL: win_elmin = longint'($signed(val[14:0]));
            rtpg_pkg::REG_MAX_EL: win_elmax = longint'($signed(val[14:0]));
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_windows(input int rmin, rmax, azmin, azmax, elmin, elmax);
        write_reg(rtpg_pkg::REG_MIN_RANGE, 25'(rmin));
        write_reg(rtpg_pkg::REG_MAX_RANGE, 25'(rmax));
        write_reg(rtpg_pkg::REG_MIN_AZ, 25'(azmin));
        write_reg(rtpg_pkg::REG_MAX_AZ, 25'(azmax));
        write_reg(rtpg_pkg::REG_MIN_EL, 25'(elmin));
        write_reg(rtpg_pkg::REG_MAX_EL, 25'(elmax));
    endtask

    initial
    begin
        int lo, hi;
        win_rmin = rtpg_pkg::MIN_RANGE_RST; win_rmax = rtpg_pkg::MAX_RANGE_RST;
        win_azmin = -rtpg_pkg::PI_Q13; win_azmax = rtpg_pkg::PI_Q13;
        win_elmin = -rtpg_pkg::HALF_PI_Q13; win_elmax = rtpg_pkg::HALF_PI_Q13;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items under the reset windows.
        add_item(mk_item(0, 0, 0, 16384, 0, 0, 0, 256, 0, 0));
        add_item(mk_item(0, 0, 0, 16384, 0, 0, 0, -256, 0, 0));
        add_item(mk_item(0, 0, 0, 16384, 0, 0, 0, 0, 256, 0));
        add_item(mk_item(0, 0, 0, 16384, 0, 0, 0, 0, -256, 0));
        add_item(mk_item(0, 0, 0, 16384, 0, 0, 0, 0, 0, 256));
        add_item(mk_item(0, 0, 0, 16384, 0, 0, 0, 0, 0, -256));
        add_item(mk_item(5, 6, 7, 16384, 0, 0, 0, 5, 6, 7));
        add_item(mk_item(0, 0, 0, 0, 0, 0, 0, 100, 200, 300));
        add_item(mk_item(0, 0, 0, 0, 0, 0, 0, 100, 200, -300));
        add_item(mk_item(-8388608, -8388608, -8388608, 16384, 0, 0, 0,
                         8388607, 8388607, 8388607));
        add_item(mk_item(8388607, 8388607, 8388607, -16384, 0, 0, 0,
                         -8388608, -8388608, -8388608));
        add_item(mk_item(8388607, -8388608, 0, 16384, 16384, 16384, 16384,
                         -8388608, 8388607, 1));
        add_item(mk_item(0, 0, 0, 1, 1, 1, 1, 1000, -1000, 500));
        add_item(mk_item(0, 0, 0, -16384, -16384, -16384, -16384, -77, 3, 9));
        add_item(mk_item(0, 0, 0, 11585, 0, 0, 11585, 4000, 0, 0));
        add_item(mk_item(0, 0, 0, 11585, 11585, 0, 0, 0, 4000, 0));
        add_item(mk_item(10, 20, 30, 16384, 0, 0, 0, -990, 20, 30));
        add_item(mk_item(0, 0, 0, 16384, 0, 0, 0, -1, -1, 0));
        add_item(mk_item(0, 0, 0, 16384, 0, 0, 0, 1, 0, 0));
        add_item(mk_item(0, 0, 0, 0, 16384, 0, 0, 3, -4, 12));
        wait_drained();

        // Random rounds, each under its own windows.
        for (int round = 0; round < 6; round++)
        begin
            send_idle = (round < 2) ? 9 : (round < 4) ? 82 : 0;
            recv_idle = (round < 2) ? 82 : (round < 4) ? 9 : 0;
            case (round)
                0: write_windows(0, 33554431, -rtpg_pkg::PI_Q13, rtpg_pkg::PI_Q13,
                                 -rtpg_pkg::HALF_PI_Q13, rtpg_pkg::HALF_PI_Q13);
                1:
                begin
                    lo = rnd_in(-rtpg_pkg::PI_Q13, 0); hi = rnd_in(0, rtpg_pkg::PI_Q13);
                    write_windows($urandom_range(1 << 20), $urandom_range(33554431, 1 << 22),
                                  lo, hi, rnd_in(-rtpg_pkg::HALF_PI_Q13, 0),
                                  rnd_in(0, rtpg_pkg::HALF_PI_Q13));
                end
                2: write_windows(33554431, 0, rtpg_pkg::PI_Q13, -rtpg_pkg::PI_Q13,
                                 rtpg_pkg::HALF_PI_Q13, -rtpg_pkg::HALF_PI_Q13);
                3: write_windows(0, 33554431, 0, rtpg_pkg::PI_Q13, 0, rtpg_pkg::HALF_PI_Q13);
                4:
                begin
                    // Indexes past the last register must change nothing.
                    write_reg(3'd6, 25'h1FFFFFF);
                    write_reg(3'd7, 25'h0);
                    write_windows(0, 33554431, rtpg_pkg::HALF_PI_Q13, rtpg_pkg::HALF_PI_Q13,
                                  -rtpg_pkg::HALF_PI_Q13, rtpg_pkg::HALF_PI_Q13);
                end
                default: write_windows(0, 33554431, -rtpg_pkg::PI_Q13, rtpg_pkg::PI_Q13,
                                       -rtpg_pkg::HALF_PI_Q13, rtpg_pkg::HALF_PI_Q13);
            endcase
            for (int n = 0; n < 283; n++)
                add_item(rand_item());
            if (round == 1)
            begin
                // Hold the sender until every result is out.
                while (item_q.size() > 140)
                    @(posedge clk);
                hold = 1;
                while (in_valid || polar_expect_q.size() > 0)
                    @(posedge clk);
                hold = 0;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("radar_target_polar_gate_tb: clean");
        else
            $display("radar_target_polar_gate_tb: errors");
        $finish;
    end

endmodule
